FILE: design/rpa_pkg.sv
package rpa_pkg;

    localparam int PAGE_COUNT = 32;
    localparam int COUNT_BITS = 8;

    // Fixed widths of the request and response fields
    localparam int MODE_BITS      = 2;
    localparam int PAGE_BITS      = 5;
    localparam int STATUS_BITS    = 3;
    localparam int OUT_COUNT_BITS = 8;

    // Internal widths that follow from the pool size
    localparam int IDX_BITS   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int DEPTH_BITS = $clog2(PAGE_COUNT + 1);

    typedef logic [MODE_BITS-1:0]      mode_t;
    typedef logic [PAGE_BITS-1:0]      page_t;
    typedef logic [STATUS_BITS-1:0]    status_t;
    typedef logic [OUT_COUNT_BITS-1:0] out_count_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [DEPTH_BITS-1:0]     depth_t;

    localparam count_t COUNT_MAX = '1;

    localparam mode_t MODE_ALLOC   = 2'd0;
    localparam mode_t MODE_RELEASE = 2'd1;
    localparam mode_t MODE_RETAIN  = 2'd2;

    localparam status_t STAT_GRANTED   = 3'd0;
    localparam status_t STAT_EMPTY     = 3'd1;
    localparam status_t STAT_RETURNED  = 3'd2;
    localparam status_t STAT_DROPPED   = 3'd3;
    localparam status_t STAT_ADDED     = 3'd4;
    localparam status_t STAT_NOT_ALLOC = 3'd5;

endpackage

FILE: design/refcounted_page_allocator.sv
// Page allocator with a LIFO free stack and a share count per page.
//
// Request channel (req_valid / req_stall) carries mode and page_index:
// allocate, release or retain. Response channel (rsp_valid / rsp_stall)
// returns granted_page, status and share_count, one response per request.
// A transfer happens on a clock edge with valid high and stall low.
//
// For each request the free stack and count memories are read in the
// transfer cycle; then the entry is updated, written back and the response
// register loaded, once that register is free or being taken. One request
// is in flight at a time, so a new request is not taken until the update
// of the previous one is done.
// The response register decouples the sides: a new request is taken while
// a response waits; if the receiver keeps stalling, the following request
// holds in its update cycle and req_stall stays high.
//
// Reset clears all control state: the pool is full with page 0 on top,
// all counts read as zero and no page is in use. No clearing pass is needed.
module refcounted_page_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rpa_pkg::mode_t      mode,
    input  rpa_pkg::page_t      page_index,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rpa_pkg::page_t      granted_page,
    output rpa_pkg::status_t    status,
    output rpa_pkg::out_count_t share_count
);
    import rpa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic       state_reg;
    logic       state_next;
    logic       req_fire;
    logic       exec_go;

    mode_t      mode_reg;
    page_t      idx_reg;
    depth_t     depth_reg;
    depth_t     depth_next;
    logic [PAGE_COUNT-1:0] in_use_reg;
    logic [PAGE_COUNT-1:0] stk_vld_reg;
    logic [PAGE_COUNT-1:0] cnt_vld_reg;
    logic       stk_rd_vld_reg;
    logic       cnt_rd_vld_reg;
    idx_t       stk_rd_addr_reg;

    logic       stk_we;
    idx_t       stk_waddr;
    idx_t       stk_wdata;
    idx_t       stk_raddr;
    idx_t       stk_rdata;
    logic       cnt_we;
    idx_t       cnt_waddr;
    count_t     cnt_wdata;
    idx_t       cnt_raddr;
    count_t     cnt_rdata;

    idx_t       stk_cur;
    count_t     cnt_cur;
    count_t     cnt_dec;
    count_t     cnt_inc;
    idx_t       idx_addr;
    logic       idx_ok;
    logic       use_set;
    logic       use_clr;
    idx_t       use_addr;

    logic       rsp_valid_reg;
    page_t      granted_page_reg;
    status_t    status_reg;
    out_count_t share_count_reg;
    page_t      page_res;
    status_t    status_res;
    count_t     count_res;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    assign stk_raddr = IDX_BITS'(depth_reg - DEPTH_BITS'(1));
    assign cnt_raddr = IDX_BITS'(page_index);

    rpa_ram #(
        .WIDTH (IDX_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (req_fire),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (req_fire),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Entries never written read back as their reset values
    assign stk_cur  = stk_rd_vld_reg ? stk_rdata
                                     : IDX_BITS'(PAGE_COUNT - 1) - stk_rd_addr_reg;
    assign cnt_cur  = cnt_rd_vld_reg ? cnt_rdata : '0;
    assign cnt_dec  = cnt_cur - COUNT_BITS'(1);
    assign cnt_inc  = (cnt_cur != COUNT_MAX) ? cnt_cur + COUNT_BITS'(1) : cnt_cur;
    assign idx_addr = IDX_BITS'(idx_reg);
    assign idx_ok   = (32'(idx_reg) < PAGE_COUNT);

    always_comb
    begin
        state_next = state_reg;
        if (req_fire)
        begin
            state_next = S_EXEC;
        end
        else if (exec_go)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        stk_we     = 1'b0;
        stk_waddr  = IDX_BITS'(depth_reg);
        stk_wdata  = idx_addr;
        cnt_we     = 1'b0;
        cnt_waddr  = idx_addr;
        cnt_wdata  = cnt_cur;
        depth_next = depth_reg;
        use_set    = 1'b0;
        use_clr    = 1'b0;
        use_addr   = idx_addr;
        page_res   = idx_reg;
        status_res = STAT_NOT_ALLOC;
        count_res  = '0;

        case (mode_reg)
            MODE_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    page_res   = '0;
                    status_res = STAT_EMPTY;
                end
                else
                begin
                    depth_next = depth_reg - DEPTH_BITS'(1);
                    cnt_we     = 1'b1;
                    cnt_waddr  = stk_cur;
                    cnt_wdata  = '0;
                    use_set    = 1'b1;
                    use_addr   = stk_cur;
                    page_res   = PAGE_BITS'(stk_cur);
                    status_res = STAT_GRANTED;
                end
            end
            MODE_RELEASE:
            begin
                if (!idx_ok)
                begin
                    status_res = STAT_NOT_ALLOC;
                end
                else if (cnt_cur != '0)
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_dec;
                    status_res = STAT_DROPPED;
                    count_res  = cnt_dec;
                end
                else if (!in_use_reg[idx_addr] || (32'(depth_reg) >= PAGE_COUNT))
                begin
                    // page already free, or the stack has no room
                    status_res = STAT_NOT_ALLOC;
                end
                else
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DEPTH_BITS'(1);
                    use_clr    = 1'b1;
                    status_res = STAT_RETURNED;
                end
            end
            MODE_RETAIN:
            begin
                if (idx_ok)
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_inc;
                    status_res = STAT_ADDED;
                    count_res  = cnt_inc;
                end
            end
            default:
            begin
                status_res = STAT_NOT_ALLOC;
                count_res  = idx_ok ? cnt_cur : '0;
            end
        endcase

        if (!exec_go)
        begin
            stk_we     = 1'b0;
            cnt_we     = 1'b0;
            use_set    = 1'b0;
            use_clr    = 1'b0;
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= DEPTH_BITS'(PAGE_COUNT);
            in_use_reg     <= '0;
            stk_vld_reg    <= '0;
            cnt_vld_reg    <= '0;
            stk_rd_vld_reg <= 1'b0;
            cnt_rd_vld_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (req_fire)
            begin
                stk_rd_vld_reg <= stk_vld_reg[stk_raddr];
                cnt_rd_vld_reg <= cnt_vld_reg[cnt_raddr];
            end
            if (stk_we)
            begin
                stk_vld_reg[stk_waddr] <= 1'b1;
            end
            if (cnt_we)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
            if (use_set)
            begin
                in_use_reg[use_addr] <= 1'b1;
            end
            else if (use_clr)
            begin
                in_use_reg[use_addr] <= 1'b0;
            end
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg        <= mode;
            idx_reg         <= page_index;
            stk_rd_addr_reg <= stk_raddr;
        end
        if (exec_go)
        begin
            granted_page_reg <= page_res;
            status_reg       <= status_res;
            share_count_reg  <= OUT_COUNT_BITS'(count_res);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted_page = granted_page_reg;
    assign status       = status_reg;
    assign share_count  = share_count_reg;

endmodule

FILE: design/rpa_ram.sv
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rpa_checker.sv
module rpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input rpa_pkg::mode_t      mode,
    input rpa_pkg::page_t      page_index,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input rpa_pkg::page_t      granted_page,
    input rpa_pkg::status_t    status,
    input rpa_pkg::out_count_t share_count
);
    import rpa_pkg::*;

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_page)
            && $stable(status) && $stable(share_count))
        else $error("stalled response changed");

    // One request in flight: the cycle after a transfer the block is busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    // A fresh grant always starts with no shares
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_GRANTED) |-> share_count == '0)
        else $error("granted page with nonzero share count");

    // Empty pool and returned pages report zero counts
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_EMPTY || status == STAT_RETURNED)
            |-> share_count == '0)
        else $error("empty or returned response with nonzero count");

    a_empty_page: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_EMPTY) |-> granted_page == '0)
        else $error("empty pool response with nonzero page");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
